// ===== hdl/ghsm_pkg.sv =====
// ============================================================================
// ghsm_pkg - shared definitions for the generational handle slot map
// Sizes, operation and status codes, shared unit operations and the result
// record used by the channel interfaces and the modules.
// ============================================================================
package ghsm_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int GEN_BITS  = 16;

    localparam int IDX_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int ALU_W    = (GEN_BITS > CNT_W) ? GEN_BITS : CNT_W;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] F_CREATE   = 2'd0;
    localparam logic [FUNC_W-1:0] F_DESTROY  = 2'd1;
    localparam logic [FUNC_W-1:0] F_VALIDATE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Shared unit operations.
    typedef enum logic [1:0] {
        ALU_LT,
        ALU_EQ,
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             flag;
        logic [ALU_W-1:0] value;
    } t_alu_rsp;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    out_index;
        logic [GEN_BITS-1:0] out_generation;
        logic [IDX_W-1:0]    dense_position;
        logic                moved;
        logic [IDX_W-1:0]    moved_from;
        logic [CNT_W-1:0]    live_entries;
    } t_rsp;

endpackage

// ===== hdl/ghsm_chan_if.sv =====
// ============================================================================
// ghsm channel interfaces - request and response channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ============================================================================
interface ghsm_in_if import ghsm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    slot_index;
    logic [GEN_BITS-1:0] slot_generation;

    modport source (output valid, output func, output slot_index,
                    output slot_generation, input ready);
    modport sink   (input valid, input func, input slot_index,
                    input slot_generation, output ready);
endinterface

interface ghsm_out_if import ghsm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    out_index;
    logic [GEN_BITS-1:0] out_generation;
    logic [IDX_W-1:0]    dense_position;
    logic                moved;
    logic [IDX_W-1:0]    moved_from;
    logic [CNT_W-1:0]    live_entries;

    modport source (output valid, output status, output out_index,
                    output out_generation, output dense_position, output moved,
                    output moved_from, output live_entries, input ready);
    modport sink   (input valid, input status, input out_index,
                    input out_generation, input dense_position, input moved,
                    input moved_from, input live_entries, output ready);
endinterface

// ===== hdl/ghsm_ram.sv =====
// ============================================================================
// ghsm_ram - simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module ghsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ghsm_alu.sv =====
// ============================================================================
// ghsm_alu - shared compare and increment unit
// Less-than, equality, increment and decrement on one operand pair.
// ============================================================================
module ghsm_alu import ghsm_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    always_comb begin
        o_rsp.flag  = 1'b0;
        o_rsp.value = '0;
        case (i_req.op)
            ALU_LT:  o_rsp.flag  = (i_req.a < i_req.b);
            ALU_EQ:  o_rsp.flag  = (i_req.a == i_req.b);
            ALU_INC: o_rsp.value = i_req.a + ALU_W'(1);
            ALU_DEC: o_rsp.value = i_req.a - ALU_W'(1);
            default: o_rsp.value = '0;
        endcase
    end

endmodule

// ===== hdl/generational_handle_slot_map.sv =====
// ============================================================================
// generational_handle_slot_map - generational handle allocator
// Sparse-set slot map with per-slot generations, a free-slot stack and
// swap-remove of the packed dense array, run by a small sequencer around one
// shared compare and increment unit.
// ============================================================================
//
//  Channel   Direction  Payload
//  -------   ---------  ---------------------------------------------------
//  i_req     in         func, slot_index, slot_generation
//  o_rsp     out        status, out_index, out_generation, dense_position,
//                       moved, moved_from, live_entries
//
//  After its transfer a request steps through the sequencer to S_DONE, which
//  loads its result into the output register. A full table or an unused code
//  goes there at once; a reused create passes S_C_POP and S_C_INC before
//  S_C_LINK, and a destroy passes the validate checks, then S_D_LAST to
//  S_D_PUSH, skipping S_D_MOVE when no entry moves. Each step makes one pass
//  through the shared unit and one read of each table, all with registered
//  read data; the sequencer then returns to idle. Reset clears the counters,
//  the sequencer and the output valid and moved flags only; the tables need
//  no clearing pass because no entry is read before it is written.
//  i_req.ready is high only while the sequencer is idle. A finished result
//  waits in the output register; the next request is taken meanwhile and
//  stalls only at its own end if the earlier result has not been taken.
//
module generational_handle_slot_map import ghsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ghsm_in_if.sink    i_req,
    ghsm_out_if.source o_rsp
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_C_POP  = 4'd2;
    localparam logic [3:0] S_C_INC  = 4'd3;
    localparam logic [3:0] S_C_LINK = 4'd4;
    localparam logic [3:0] S_H_LIVE = 4'd5;
    localparam logic [3:0] S_H_MAP  = 4'd6;
    localparam logic [3:0] S_H_GEN  = 4'd7;
    localparam logic [3:0] S_D_LAST = 4'd8;
    localparam logic [3:0] S_D_CMP  = 4'd9;
    localparam logic [3:0] S_D_MOVE = 4'd10;
    localparam logic [3:0] S_D_BUMP = 4'd11;
    localparam logic [3:0] S_D_PUSH = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0]          r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [IDX_W-1:0]    r_s, n_s;
    logic [GEN_BITS-1:0] r_g, n_g;
    logic [IDX_W-1:0]    r_d, n_d;
    logic [GEN_BITS-1:0] r_gen, n_gen;
    logic [CNT_W-1:0]    r_last, n_last;
    logic                r_moved, n_moved;
    logic [CNT_W-1:0]    r_free_top, n_free_top;
    logic [CNT_W-1:0]    r_live, n_live;
    logic [CNT_W-1:0]    r_fresh, n_fresh;
    t_rsp                r_res, n_res;
    t_rsp                r_out, n_out;
    logic                r_out_valid, n_out_valid;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    // Table ports.
    logic                std_we, dts_we, gen_we, fst_we;
    logic [IDX_W-1:0]    std_waddr, dts_waddr, gen_waddr, fst_waddr;
    logic [IDX_W-1:0]    std_wdata, dts_wdata, fst_wdata;
    logic [GEN_BITS-1:0] gen_wdata;
    logic [IDX_W-1:0]    std_raddr, dts_raddr, gen_raddr, fst_raddr;
    logic [IDX_W-1:0]    std_rdata, dts_rdata, fst_rdata;
    logic [GEN_BITS-1:0] gen_rdata;

    function automatic t_rsp mk_rsp(
        input logic [STATUS_W-1:0] status,
        input logic [IDX_W-1:0]    idx,
        input logic [GEN_BITS-1:0] gen,
        input logic [IDX_W-1:0]    dpos,
        input logic                mv,
        input logic [IDX_W-1:0]    mfrom,
        input logic [CNT_W-1:0]    live
    );
        t_rsp r;
        r.status         = status;
        r.out_index      = idx;
        r.out_generation = gen;
        r.dense_position = dpos;
        r.moved          = mv;
        r.moved_from     = mfrom;
        r.live_entries   = live;
        return r;
    endfunction

    ghsm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Slot to dense position.
    ghsm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_std (
        .i_clk   (i_clk),
        .i_we    (std_we),
        .i_waddr (std_waddr),
        .i_wdata (std_wdata),
        .i_raddr (std_raddr),
        .o_rdata (std_rdata)
    );

    // Dense position to slot.
    ghsm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_dts (
        .i_clk   (i_clk),
        .i_we    (dts_we),
        .i_waddr (dts_waddr),
        .i_wdata (dts_wdata),
        .i_raddr (dts_raddr),
        .o_rdata (dts_rdata)
    );

    // Generation per slot.
    ghsm_ram #(.WIDTH(GEN_BITS), .DEPTH(MAX_SLOTS)) u_gen (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    // Stack of freed slots.
    ghsm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_fst (
        .i_clk   (i_clk),
        .i_we    (fst_we),
        .i_waddr (fst_waddr),
        .i_wdata (fst_wdata),
        .i_raddr (fst_raddr),
        .o_rdata (fst_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_s         = r_s;
        n_g         = r_g;
        n_d         = r_d;
        n_gen       = r_gen;
        n_last      = r_last;
        n_moved     = r_moved;
        n_free_top  = r_free_top;
        n_live      = r_live;
        n_fresh     = r_fresh;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        alu_req.op = ALU_EQ;
        alu_req.a  = '0;
        alu_req.b  = '0;

        std_we    = 1'b0;
        std_waddr = r_s;
        std_wdata = r_d;
        std_raddr = r_s;
        dts_we    = 1'b0;
        dts_waddr = r_d;
        dts_wdata = r_s;
        dts_raddr = r_d;
        gen_we    = 1'b0;
        gen_waddr = r_s;
        gen_wdata = r_gen;
        gen_raddr = r_s;
        fst_we    = 1'b0;
        fst_waddr = r_free_top[IDX_W-1:0];
        fst_wdata = r_s;
        fst_raddr = r_free_top[IDX_W-1:0];

        // The output register is emptied by a transfer on the response side.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_s     = i_req.slot_index;
                    n_g     = i_req.slot_generation;
                    n_state = S_START;
                end
            end

            S_START: begin
                if (r_func == F_CREATE) begin
                    if (r_free_top != '0) begin
                        // Pop the most recently freed slot.
                        alu_req.op = ALU_DEC;
                        alu_req.a  = ALU_W'(r_free_top);
                        n_free_top = alu_rsp.value[CNT_W-1:0];
                        fst_raddr  = alu_rsp.value[IDX_W-1:0];
                        n_state    = S_C_POP;
                    end else if (r_fresh != CNT_W'(MAX_SLOTS)) begin
                        // Take the next fresh slot at generation zero.
                        alu_req.op = ALU_INC;
                        alu_req.a  = ALU_W'(r_fresh);
                        n_fresh    = alu_rsp.value[CNT_W-1:0];
                        n_s        = r_fresh[IDX_W-1:0];
                        n_gen      = '0;
                        gen_we     = 1'b1;
                        gen_waddr  = r_fresh[IDX_W-1:0];
                        gen_wdata  = '0;
                        n_state    = S_C_LINK;
                    end else begin
                        n_res   = mk_rsp(ST_FULL, '0, '0, '0, 1'b0, '0, r_live);
                        n_state = S_DONE;
                    end
                end else if (r_func inside {F_DESTROY, F_VALIDATE}) begin
                    // A handle must name a slot that has been handed out.
                    alu_req.op = ALU_LT;
                    alu_req.a  = ALU_W'(r_s);
                    alu_req.b  = ALU_W'(r_fresh);
                    if (alu_rsp.flag) begin
                        n_state = S_H_LIVE;
                    end else begin
                        n_res   = mk_rsp(ST_INVALID, r_s, '0, '0, 1'b0, '0, r_live);
                        n_state = S_DONE;
                    end
                end else begin
                    n_res   = mk_rsp(ST_INVALID, r_s, '0, '0, 1'b0, '0, r_live);
                    n_state = S_DONE;
                end
            end

            S_C_POP: begin
                n_s       = fst_rdata;
                gen_raddr = fst_rdata;
                n_state   = S_C_INC;
            end

            S_C_INC: begin
                alu_req.op = ALU_INC;
                alu_req.a  = ALU_W'(gen_rdata);
                n_gen      = alu_rsp.value[GEN_BITS-1:0];
                gen_we     = 1'b1;
                gen_waddr  = r_s;
                gen_wdata  = alu_rsp.value[GEN_BITS-1:0];
                n_state    = S_C_LINK;
            end

            S_C_LINK: begin
                // Append the slot at the end of the dense array.
                std_we     = 1'b1;
                std_waddr  = r_s;
                std_wdata  = r_live[IDX_W-1:0];
                dts_we     = 1'b1;
                dts_waddr  = r_live[IDX_W-1:0];
                dts_wdata  = r_s;
                alu_req.op = ALU_INC;
                alu_req.a  = ALU_W'(r_live);
                n_live     = alu_rsp.value[CNT_W-1:0];
                n_res      = mk_rsp(ST_OK, r_s, r_gen, r_live[IDX_W-1:0], 1'b0, '0,
                                    alu_rsp.value[CNT_W-1:0]);
                n_state    = S_DONE;
            end

            S_H_LIVE: begin
                n_d        = std_rdata;
                n_gen      = gen_rdata;
                dts_raddr  = std_rdata;
                alu_req.op = ALU_LT;
                alu_req.a  = ALU_W'(std_rdata);
                alu_req.b  = ALU_W'(r_live);
                if (alu_rsp.flag) begin
                    n_state = S_H_MAP;
                end else begin
                    n_res   = mk_rsp(ST_INVALID, r_s, '0, '0, 1'b0, '0, r_live);
                    n_state = S_DONE;
                end
            end

            S_H_MAP: begin
                // A freed slot no longer maps back from its old dense position.
                alu_req.op = ALU_EQ;
                alu_req.a  = ALU_W'(dts_rdata);
                alu_req.b  = ALU_W'(r_s);
                if (alu_rsp.flag) begin
                    n_state = S_H_GEN;
                end else begin
                    n_res   = mk_rsp(ST_INVALID, r_s, '0, '0, 1'b0, '0, r_live);
                    n_state = S_DONE;
                end
            end

            S_H_GEN: begin
                alu_req.op = ALU_EQ;
                alu_req.a  = ALU_W'(r_gen);
                alu_req.b  = ALU_W'(r_g);
                if (!alu_rsp.flag) begin
                    n_res   = mk_rsp(ST_INVALID, r_s, '0, '0, 1'b0, '0, r_live);
                    n_state = S_DONE;
                end else if (r_func == F_VALIDATE) begin
                    n_res   = mk_rsp(ST_OK, r_s, r_gen, r_d, 1'b0, '0, r_live);
                    n_state = S_DONE;
                end else begin
                    n_state = S_D_LAST;
                end
            end

            S_D_LAST: begin
                // The handle check guarantees at least one live entry.
                alu_req.op = ALU_DEC;
                alu_req.a  = ALU_W'(r_live);
                n_last     = alu_rsp.value[CNT_W-1:0];
                n_live     = alu_rsp.value[CNT_W-1:0];
                n_state    = S_D_CMP;
            end

            S_D_CMP: begin
                alu_req.op = ALU_EQ;
                alu_req.a  = ALU_W'(r_d);
                alu_req.b  = ALU_W'(r_last);
                dts_raddr  = r_last[IDX_W-1:0];
                if (alu_rsp.flag) begin
                    n_moved = 1'b0;
                    n_state = S_D_BUMP;
                end else begin
                    n_moved = 1'b1;
                    n_state = S_D_MOVE;
                end
            end

            S_D_MOVE: begin
                // Move the last dense entry into the hole left by this slot.
                std_we    = 1'b1;
                std_waddr = dts_rdata;
                std_wdata = r_d;
                dts_we    = 1'b1;
                dts_waddr = r_d;
                dts_wdata = dts_rdata;
                n_state   = S_D_BUMP;
            end

            S_D_BUMP: begin
                alu_req.op = ALU_INC;
                alu_req.a  = ALU_W'(r_gen);
                n_gen      = alu_rsp.value[GEN_BITS-1:0];
                gen_we     = 1'b1;
                gen_waddr  = r_s;
                gen_wdata  = alu_rsp.value[GEN_BITS-1:0];
                fst_we     = 1'b1;
                fst_waddr  = r_free_top[IDX_W-1:0];
                fst_wdata  = r_s;
                n_state    = S_D_PUSH;
            end

            S_D_PUSH: begin
                alu_req.op = ALU_INC;
                alu_req.a  = ALU_W'(r_free_top);
                n_free_top = alu_rsp.value[CNT_W-1:0];
                n_res      = mk_rsp(ST_OK, r_s, r_gen, r_d, r_moved,
                                    r_moved ? r_last[IDX_W-1:0] : '0, r_live);
                n_state    = S_DONE;
            end

            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_top  <= '0;
            r_live      <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
            r_moved     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_top  <= n_free_top;
            r_live      <= n_live;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            r_moved     <= n_moved;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_s    <= n_s;
        r_g    <= n_g;
        r_d    <= n_d;
        r_gen  <= n_gen;
        r_last <= n_last;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.out_index      = r_out.out_index;
    assign o_rsp.out_generation = r_out.out_generation;
    assign o_rsp.dense_position = r_out.dense_position;
    assign o_rsp.moved          = r_out.moved;
    assign o_rsp.moved_from     = r_out.moved_from;
    assign o_rsp.live_entries   = r_out.live_entries;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb - self-checking testbench for generational_handle_slot_map
// Drives create, destroy and validate requests over the request channel and
// checks every response field by field against an in-bench model of the
// slot map (sparse/dense maps, generations, free stack, counters). A short
// table of directed requests comes first, then random traffic in phases:
// churn, fill to full, drain and churn again. Both channels stall at random.
// ============================================================================
module tb import ghsm_pkg::*; ();

    // The unused operation code answers like an invalid handle.
    localparam logic [FUNC_W-1:0] F_UNUSED = 2'd3;

    // A correct run needs well under a millisecond; allow several times that.
    localparam int TIMEOUT_NS = 5_000_000;
    // Margin for the longest request through the sequencer and the output register.
    localparam int SETTLE_CYCLES = 16;
    localparam int END_WAIT_CYCLES = 4000;

    localparam t_rsp NO_RSP = '0;

    typedef enum {MIX_CHURN, MIX_FILL, MIX_DRAIN} t_mix;
    typedef enum {PICK_CREATE, PICK_DESTROY, PICK_VALIDATE, PICK_STALE, PICK_BADGEN,
                  PICK_NOISE} t_pick;

    // One row of the directed table. Where typed is set, want holds the
    // response read straight off the behavior; otherwise the model decides.
    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [IDX_W-1:0]    idx;
        logic [GEN_BITS-1:0] gen;
        bit                  typed;
        t_rsp                want;
    } t_step;

    logic clk;
    logic rst_n;

    ghsm_in_if  req_if ();
    ghsm_out_if rsp_if ();

    generational_handle_slot_map DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // ------------------------------------------------------------------------
    // Model state of the slot map. Entries of the arrays are only ever read
    // after the model itself has written them, just like in the block.
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]    slot_dense  [MAX_SLOTS];
    logic [IDX_W-1:0]    dense_slot  [MAX_SLOTS];
    logic [GEN_BITS-1:0] slot_gens   [MAX_SLOTS];
    logic [IDX_W-1:0]    freed_slots [MAX_SLOTS];
    int free_depth = 0;
    int live_cnt   = 0;
    int fresh_cnt  = 0;

    // Responses still owed by the block, oldest first.
    t_rsp pending_rsps [$];
    int   fault_count = 0;

    bit send_calm = 1'b0;
    int send_calm_left = 0;
    bit take_calm = 1'b0;
    int take_calm_left = 0;

    // Directed table: empty-table errors, first creates, lookups with a wrong
    // generation and an unused slot, swap-remove with and without a move,
    // a freed slot at its bumped generation, reuse from the free stack (a
    // reused slot comes back two generations up) and a double destroy.
    t_step directed_ops [18] = '{
        '{F_VALIDATE, 8'h00, 16'h0000, 1'b1, '{ST_INVALID, 8'h00, 16'h0, 8'h0, 1'b0, 8'h0, 9'd0}},
        '{F_DESTROY,  8'hFF, 16'hFFFF, 1'b1, '{ST_INVALID, 8'hFF, 16'h0, 8'h0, 1'b0, 8'h0, 9'd0}},
        '{F_UNUSED,   8'hAA, 16'h5555, 1'b1, '{ST_INVALID, 8'hAA, 16'h0, 8'h0, 1'b0, 8'h0, 9'd0}},
        '{F_CREATE,   8'h00, 16'h0000, 1'b1, '{ST_OK,      8'h00, 16'h0, 8'h0, 1'b0, 8'h0, 9'd1}},
        '{F_CREATE,   8'hFF, 16'hFFFF, 1'b1, '{ST_OK,      8'h01, 16'h0, 8'h1, 1'b0, 8'h0, 9'd2}},
        '{F_CREATE,   8'h00, 16'h0000, 1'b1, '{ST_OK,      8'h02, 16'h0, 8'h2, 1'b0, 8'h0, 9'd3}},
        '{F_VALIDATE, 8'h01, 16'h0000, 1'b0, NO_RSP},
        '{F_VALIDATE, 8'h01, 16'h0001, 1'b1, '{ST_INVALID, 8'h01, 16'h0, 8'h0, 1'b0, 8'h0, 9'd3}},
        '{F_VALIDATE, 8'h03, 16'h0000, 1'b1, '{ST_INVALID, 8'h03, 16'h0, 8'h0, 1'b0, 8'h0, 9'd3}},
        '{F_DESTROY,  8'h00, 16'h0000, 1'b0, NO_RSP},
        '{F_VALIDATE, 8'h00, 16'h0001, 1'b1, '{ST_INVALID, 8'h00, 16'h0, 8'h0, 1'b0, 8'h0, 9'd2}},
        '{F_DESTROY,  8'h02, 16'h0000, 1'b0, NO_RSP},
        '{F_DESTROY,  8'h01, 16'h0000, 1'b0, NO_RSP},
        '{F_CREATE,   8'h00, 16'h0000, 1'b0, NO_RSP},
        '{F_UNUSED,   8'h55, 16'hFFFF, 1'b1, '{ST_INVALID, 8'h55, 16'h0, 8'h0, 1'b0, 8'h0, 9'd1}},
        '{F_VALIDATE, 8'h01, 16'h0002, 1'b0, NO_RSP},
        '{F_DESTROY,  8'h01, 16'h0002, 1'b0, NO_RSP},
        '{F_DESTROY,  8'h01, 16'h0002, 1'b1, '{ST_INVALID, 8'h01, 16'h0, 8'h0, 1'b0, 8'h0, 9'd0}}
    };

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: done, errors");
        $finish;
    end

    // A handle is live when its slot has been handed out, its dense position
    // lies inside the packed region and points back to it, and its
    // generation matches. A freed slot fails the dense check.
    function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_BITS-1:0] gen);
        int d;
        if (int'(idx) >= fresh_cnt)
            return 1'b0;
        d = int'(slot_dense[idx]);
        if (d >= live_cnt)
            return 1'b0;
        if (dense_slot[d] != idx)
            return 1'b0;
        return slot_gens[idx] == gen;
    endfunction

    // Applies one accepted request to the model and returns the response
    // that the block owes for it.
    function automatic t_rsp slot_map_apply(logic [FUNC_W-1:0] op, logic [IDX_W-1:0] idx,
                                            logic [GEN_BITS-1:0] gen);
        t_rsp r;
        logic [IDX_W-1:0] s;
        int d;
        int last;
        logic [IDX_W-1:0] ls;
        r = '0;
        s = idx;
        if (op == F_CREATE) begin
            if (free_depth > 0) begin
                // Most recently freed slot first, one generation further on.
                free_depth--;
                s = freed_slots[free_depth];
                slot_gens[s] = slot_gens[s] + 1'b1;
            end else if (fresh_cnt < MAX_SLOTS) begin
                s = IDX_W'(fresh_cnt);
                slot_gens[s] = '0;
                fresh_cnt++;
            end else begin
                r.status = ST_FULL;
                r.live_entries = CNT_W'(live_cnt);
                return r;
            end
            d = live_cnt;
            slot_dense[s] = IDX_W'(d);
            dense_slot[d] = s;
            live_cnt++;
            r.status = ST_OK;
            r.out_index = s;
            r.out_generation = slot_gens[s];
            r.dense_position = IDX_W'(d);
            r.live_entries = CNT_W'(live_cnt);
            return r;
        end

        if (!((op inside {F_DESTROY, F_VALIDATE}) && handle_live(idx, gen))) begin
            r.status = ST_INVALID;
            r.out_index = idx;
            r.live_entries = CNT_W'(live_cnt);
            return r;
        end

        d = int'(slot_dense[idx]);
        r.status = ST_OK;
        r.out_index = idx;
        r.dense_position = IDX_W'(d);
        if (op == F_DESTROY) begin
            // Swap-remove: the last dense entry fills the hole unless the
            // removed entry was the last one itself.
            last = live_cnt - 1;
            if (d != last) begin
                ls = dense_slot[last];
                slot_dense[ls] = IDX_W'(d);
                dense_slot[d] = ls;
                r.moved = 1'b1;
                r.moved_from = IDX_W'(last);
            end
            live_cnt = last;
            slot_gens[idx] = slot_gens[idx] + 1'b1;
            freed_slots[free_depth] = idx;
            free_depth++;
        end
        r.out_generation = slot_gens[idx];
        r.live_entries = CNT_W'(live_cnt);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("tb: %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        fault_count++;
    endtask

    // Most gaps are short, a few are long, and in calm stretches there are none.
    function automatic int idle_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Response side: ready is redrawn at every falling edge, and transfers
    // are checked at the rising edge against the oldest expected response.
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        hold = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (take_calm_left == 0) begin
                take_calm = ($urandom_range(0, 3) == 0);
                take_calm_left = $urandom_range(20, 80);
            end else begin
                take_calm_left--;
            end
            if (hold > 0) begin
                rsp_if.ready = 1'b0;
                hold--;
            end else begin
                rsp_if.ready = 1'b1;
                hold = idle_gap(take_calm);
            end
        end
    end

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsps.size() == 0) begin
                report_mismatch("response with nothing expected, status", rsp_if.status, 0);
            end else begin
                want = pending_rsps.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.out_index !== want.out_index)
                    report_mismatch("out_index", rsp_if.out_index, want.out_index);
                if (rsp_if.out_generation !== want.out_generation)
                    report_mismatch("out_generation", rsp_if.out_generation,
                                    want.out_generation);
                if (rsp_if.dense_position !== want.dense_position)
                    report_mismatch("dense_position", rsp_if.dense_position,
                                    want.dense_position);
                if (rsp_if.moved !== want.moved)
                    report_mismatch("moved", rsp_if.moved, want.moved);
                if (rsp_if.moved_from !== want.moved_from)
                    report_mismatch("moved_from", rsp_if.moved_from, want.moved_from);
                if (rsp_if.live_entries !== want.live_entries)
                    report_mismatch("live_entries", rsp_if.live_entries, want.live_entries);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Every task starts and ends at a falling edge, so that
    // valid is written at most once per edge: it stays high across
    // back-to-back transfers and is only lowered for a gap.
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [GEN_BITS-1:0] gen, input bit typed,
                           input t_rsp want);
        t_rsp predicted;
        int gap;
        if (send_calm_left == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_calm_left = $urandom_range(20, 80);
        end else begin
            send_calm_left--;
        end
        req_if.func = op;
        req_if.slot_index = idx;
        req_if.slot_generation = gen;
        req_if.valid = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        // The transfer happened at this edge; the model moves on with it.
        predicted = slot_map_apply(op, idx, gen);
        pending_rsps.insert(pending_rsps.size(), typed ? want : predicted);
        @(negedge clk);
        gap = idle_gap(send_calm);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Holds the request channel quiet until every owed response has arrived.
    task automatic wait_all_answered();
        req_if.valid = 1'b0;
        while (pending_rsps.size() > 0)
            @(negedge clk);
    endtask

    // Draws one random request. Creates aside, most requests use handles that
    // the model knows to be live, so that destroys and swap-removes happen
    // often; the rest are stale handles, wrong generations and raw noise.
    task automatic rand_op(input t_mix mix);
        int r;
        int k;
        t_pick pick;
        logic [FUNC_W-1:0] op;
        logic [IDX_W-1:0] s;
        logic [GEN_BITS-1:0] g;
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL) begin
            pick = (r < 95) ? PICK_CREATE : PICK_VALIDATE;
        end else if (mix == MIX_DRAIN) begin
            if (r < 75)      pick = PICK_DESTROY;
            else if (r < 85) pick = PICK_VALIDATE;
            else if (r < 92) pick = PICK_STALE;
            else             pick = PICK_NOISE;
        end else begin
            if (r < 35)      pick = PICK_CREATE;
            else if (r < 60) pick = PICK_DESTROY;
            else if (r < 75) pick = PICK_VALIDATE;
            else if (r < 83) pick = PICK_STALE;
            else if (r < 90) pick = PICK_BADGEN;
            else             pick = PICK_NOISE;
        end
        if (live_cnt == 0 && (pick inside {PICK_DESTROY, PICK_VALIDATE, PICK_BADGEN}))
            pick = PICK_CREATE;
        if (free_depth == 0 && pick == PICK_STALE)
            pick = PICK_NOISE;

        // A create ignores the handle fields, so they carry random bits.
        op = F_CREATE;
        s = IDX_W'($urandom_range(0, MAX_SLOTS - 1));
        g = GEN_BITS'($urandom_range(0, 65535));
        case (pick)
            PICK_DESTROY, PICK_VALIDATE, PICK_BADGEN: begin
                k = $urandom_range(0, live_cnt - 1);
                s = dense_slot[k];
                g = slot_gens[s];
                if (pick == PICK_DESTROY)
                    op = F_DESTROY;
                else if (pick == PICK_VALIDATE)
                    op = F_VALIDATE;
                else begin
                    op = $urandom_range(0, 1) ? F_DESTROY : F_VALIDATE;
                    g = g ^ (GEN_BITS'(1) << $urandom_range(0, GEN_BITS - 1));
                end
            end
            PICK_STALE: begin
                // A freed slot, at its bumped or at its old generation.
                k = $urandom_range(0, free_depth - 1);
                s = freed_slots[k];
                g = slot_gens[s] - GEN_BITS'($urandom_range(0, 1));
                op = $urandom_range(0, 1) ? F_DESTROY : F_VALIDATE;
            end
            PICK_NOISE: begin
                op = FUNC_W'($urandom_range(0, 3));
            end
            default: ;
        endcase
        send_op(op, s, g, 1'b0, NO_RSP);
    endtask

    initial begin
        int waited;
        req_if.valid = 1'b0;
        req_if.func = F_CREATE;
        req_if.slot_index = '0;
        req_if.slot_generation = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_ops[i])
            send_op(directed_ops[i].op, directed_ops[i].idx, directed_ops[i].gen,
                    directed_ops[i].typed, directed_ops[i].want);
        wait_all_answered();

        repeat (30) rand_op(MIX_CHURN);
        wait_all_answered();

        // Fill every slot, then ask for more: the table reports full.
        while (free_depth > 0 || fresh_cnt < MAX_SLOTS)
            rand_op(MIX_FILL);
        repeat (3)
            send_op(F_CREATE, '0, '0, 1'b1,
                    '{ST_FULL, 8'h00, 16'h0, 8'h0, 1'b0, 8'h0, 9'd256});

        repeat (60) rand_op(MIX_DRAIN);
        wait_all_answered();
        repeat (30) rand_op(MIX_CHURN);

        // Let the last responses come out, within a bound.
        req_if.valid = 1'b0;
        waited = 0;
        while (pending_rsps.size() > 0 && waited < END_WAIT_CYCLES) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (pending_rsps.size() > 0) begin
            report_mismatch("response never came, status", 0, pending_rsps[0].status);
            void'(pending_rsps.pop_front());
        end

        if (fault_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
